// File: design/zps_pkg.sv
// Package for the z-buffered point splatter.
// Holds the queue entry, memory word and back-end state types shared by the
// front end, the queue and the back end. No dependencies.
package zps_pkg;

   // Widest pixel address that any legal screen size needs (4096 x 4096).
   localparam int MAX_AW = 24;

   // Request opcodes as they arrive on the input channel.
   localparam logic [1:0] OP_PLOT  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SCALE   = 2'd0;
   localparam logic [1:0] CSR_SHIFT_X = 2'd1;
   localparam logic [1:0] CSR_SHIFT_Y = 2'd2;

   // What the back end has to do with a classified request.
   typedef enum logic [1:0] {
      BOP_NONE,
      BOP_PLOT,
      BOP_READ,
      BOP_CLEAR
   } bop_type;

   typedef struct packed {
      bop_type            op;
      logic [MAX_AW-1:0]  addr;
      logic [17:0]        idx;
      logic signed [23:0] z;
      logic [7:0]         bri;
   } entry_type;

   typedef struct packed {
      logic               valid;
      logic [7:0]         bri;
      logic signed [23:0] depth;
   } pix_word_type;

   typedef enum logic {
      BK_SWEEP,
      BK_RUN
   } bk_state_type;

endpackage

// File: design/zps_if.sv
// Channel interfaces for the z-buffered point splatter: request, response
// and configuration write. Depends on nothing.
interface zps_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [23:0] point_x;
   logic signed [23:0] point_y;
   logic signed [23:0] point_z;
   logic [7:0]         point_brightness;
   logic               point_masked;
   logic [17:0]        read_index;
   modport source (output valid, op, point_x, point_y, point_z, point_brightness,
                   point_masked, read_index, input ready);
   modport sink (input valid, op, point_x, point_y, point_z, point_brightness,
                 point_masked, read_index, output ready);
endinterface

interface zps_rsp_if;
   logic               valid;
   logic               ready;
   logic               drawn;
   logic [17:0]        pixel_index;
   logic [7:0]         pixel_brightness;
   logic signed [23:0] pixel_depth;
   logic               pixel_occupied;
   modport source (output valid, drawn, pixel_index, pixel_brightness, pixel_depth,
                   pixel_occupied, input ready);
   modport sink (input valid, drawn, pixel_index, pixel_brightness, pixel_depth,
                 pixel_occupied, output ready);
endinterface

interface zps_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: design/zps_front.sv
// Front end: accepts requests, projects points and classifies each request
// into a queue entry over three pipeline stages. Depends on zps_pkg, zps_if.
module zps_front #(
   parameter int SCREEN_W = 512,
   parameter int SCREEN_H = 512
) (
   input  logic                clock,
   input  logic                reset,
   zps_req_if.sink             req_chan,
   input  logic [23:0]         scale,
   input  logic signed [15:0]  shift_x,
   input  logic signed [15:0]  shift_y,
   output logic                push,
   output zps_pkg::entry_type  push_entry,
   input  logic                full
);
   localparam int XW   = $clog2(SCREEN_W);
   localparam int YW   = $clog2(SCREEN_H);
   localparam int NPIX = SCREEN_W * SCREEN_H;

   // Stage 1: products.
   logic               v1_ff, v1_in;
   logic [1:0]         op1_ff;
   logic signed [48:0] prodx_ff, prody_ff;
   logic signed [23:0] z1_ff;
   logic [7:0]         bri1_ff;
   logic               mask1_ff;
   logic [17:0]        ridx1_ff;

   // Stage 2: screen coordinates and class.
   logic               v2_ff, v2_in;
   zps_pkg::bop_type   op2_ff, op2_in;
   logic [XW-1:0]      x2_ff;
   logic [YW-1:0]      row2_ff;
   logic [17:0]        ridx2_ff, ridx2_in;
   logic signed [23:0] z2_ff;
   logic [7:0]         bri2_ff;

   // Stage 3: final entry.
   logic                v3_ff, v3_in;
   zps_pkg::entry_type  e3_ff, e3_in;

   logic free1, free2, free3;
   logic signed [17:0] offx, offy;
   logic signed [49:0] accx, accy;
   logic signed [25:0] qx, qy;
   logic inx, iny, vis;
   logic [31:0] addr32;

   assign free3 = !v3_ff || !full;
   assign free2 = !v2_ff || free3;
   assign free1 = !v1_ff || free2;
   assign req_chan.ready = free1;
   assign push = v3_ff && !full;
   assign push_entry = e3_ff;

   assign v1_in = free1 ? req_chan.valid : v1_ff;
   assign v2_in = free2 ? v1_ff : v2_ff;
   assign v3_in = free3 ? v2_ff : v3_ff;

   // Truncation toward zero: an arithmetic shift floors, so a negative sum
   // with a non-zero fraction is moved up by one.
   always_comb begin
      offx = 18'(SCREEN_W / 2) + 18'(shift_x);
      offy = 18'(SCREEN_H / 2) + 18'(shift_y);
      accx = 50'(prodx_ff) + (50'(offx) <<< 24);
      accy = 50'(prody_ff) + (50'(offy) <<< 24);
      qx = accx[49:24] + 26'((accx[49] && (accx[23:0] != 24'd0)) ? 1 : 0);
      qy = accy[49:24] + 26'((accy[49] && (accy[23:0] != 24'd0)) ? 1 : 0);
      inx = !qx[25] && (qx < 26'(SCREEN_W));
      iny = !qy[25] && (qy < 26'(SCREEN_H));
      vis = !mask1_ff && inx && iny;
      ridx2_in = 18'd0;
      unique case (op1_ff)
         zps_pkg::OP_PLOT: begin
            op2_in = vis ? zps_pkg::BOP_PLOT : zps_pkg::BOP_NONE;
         end
         zps_pkg::OP_READ: begin
            op2_in = (32'(ridx1_ff) < 32'(NPIX)) ? zps_pkg::BOP_READ : zps_pkg::BOP_NONE;
            ridx2_in = ridx1_ff;
         end
         zps_pkg::OP_CLEAR: begin
            op2_in = zps_pkg::BOP_CLEAR;
         end
         default: begin
            op2_in = zps_pkg::BOP_NONE;
         end
      endcase
   end

   always_comb begin
      addr32 = 32'(x2_ff) + 32'(row2_ff) * 32'(SCREEN_W);
      e3_in.op  = op2_ff;
      e3_in.z   = z2_ff;
      e3_in.bri = bri2_ff;
      if (op2_ff == zps_pkg::BOP_PLOT) begin
         e3_in.addr = addr32[zps_pkg::MAX_AW-1:0];
         e3_in.idx  = addr32[17:0];
      end else begin
         e3_in.addr = zps_pkg::MAX_AW'(ridx2_ff);
         e3_in.idx  = ridx2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free1) begin
         op1_ff   <= req_chan.op;
         prodx_ff <= 49'($signed(req_chan.point_x) * $signed({1'b0, scale}));
         prody_ff <= 49'($signed(req_chan.point_y) * $signed({1'b0, scale}));
         z1_ff    <= req_chan.point_z;
         bri1_ff  <= req_chan.point_brightness;
         mask1_ff <= req_chan.point_masked;
         ridx1_ff <= req_chan.read_index;
      end
      if (free2) begin
         op2_ff   <= op2_in;
         x2_ff    <= qx[XW-1:0];
         row2_ff  <= YW'(SCREEN_H - 1) - qy[YW-1:0];
         ridx2_ff <= ridx2_in;
         z2_ff    <= z1_ff;
         bri2_ff  <= bri1_ff;
      end
      if (free3) begin
         e3_ff <= e3_in;
      end
   end
endmodule

// File: design/zps_queue.sv
// Short queue between the front end and the back end of the point splatter.
// Depends on zps_pkg.
module zps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  zps_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output zps_pkg::entry_type head
);
   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   zps_pkg::entry_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;

   assign full       = cnt_ff == (PW + 1)'(DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head       = slots_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW + 1)'(push) - (PW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end
endmodule

// File: design/zps_back.sv
// Back end: pixel memory, depth test with write forwarding, clearing sweep
// and the response register. Depends on zps_pkg and zps_if.
module zps_back #(
   parameter int SCREEN_W = 512,
   parameter int SCREEN_H = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  zps_pkg::entry_type head,
   output logic               pop,
   zps_rsp_if.source          rsp_chan
);
   localparam int NPIX = SCREEN_W * SCREEN_H;
   localparam int AW   = $clog2(NPIX);

   zps_pkg::pix_word_type mem [NPIX];
   zps_pkg::pix_word_type rd_ff, lw_data_ff, cur, wd;

   zps_pkg::bk_state_type state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in, lw_addr_ff, wa;
   logic          lw_en_ff, clr_pend_ff, clr_pend_in;
   logic          we, move, start_clear, sweep_last, load_clear;

   logic               b_v_ff, b_v_in;
   zps_pkg::entry_type b_ff;
   logic               b_fire, b_write, out_free;
   logic               fwd;

   logic        rv_ff, rv_in;
   logic        r_drawn_ff;
   logic [17:0] r_idx_ff;
   logic [7:0]  r_bri_ff;
   logic signed [23:0] r_dep_ff;
   logic        r_occ_ff;

   assign sweep_last = sweep_ff == AW'(NPIX - 1);
   assign out_free   = !rv_ff || rsp_chan.ready;
   assign b_fire     = b_v_ff && out_free;

   // The entry in stage B read memory in the same cycle as the previous
   // entry wrote it, so that write is taken from the last-write register.
   assign fwd = lw_en_ff && (lw_addr_ff == b_ff.addr[AW-1:0]);
   assign cur = fwd ? lw_data_ff : rd_ff;
   assign b_write = b_fire && (b_ff.op == zps_pkg::BOP_PLOT) &&
                    (!cur.valid || (cur.depth < b_ff.z));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         zps_pkg::BK_SWEEP: begin
            if (sweep_last) state_in = zps_pkg::BK_RUN;
         end
         zps_pkg::BK_RUN: begin
            if (start_clear) state_in = zps_pkg::BK_SWEEP;
         end
         default: state_in = zps_pkg::BK_RUN;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      start_clear = 1'b0;
      move        = 1'b0;
      load_clear  = 1'b0;
      unique case (state_ff)
         zps_pkg::BK_SWEEP: begin
            load_clear = sweep_last && clr_pend_ff;
         end
         zps_pkg::BK_RUN: begin
            if (head_valid) begin
               if (head.op == zps_pkg::BOP_CLEAR) start_clear = !b_v_ff;
               else move = !b_v_ff || b_fire;
            end
         end
         default: ;
      endcase
   end

   assign pop = move || start_clear;
   assign sweep_in = (state_ff == zps_pkg::BK_SWEEP) ? sweep_ff + 1'b1 : '0;
   assign clr_pend_in = start_clear ? 1'b1 : (sweep_last ? 1'b0 : clr_pend_ff);
   assign b_v_in = move || load_clear || (b_v_ff && !b_fire);
   assign rv_in = b_fire || (rv_ff && !rsp_chan.ready);

   always_comb begin
      if (state_ff == zps_pkg::BK_SWEEP) begin
         we = 1'b1;
         wa = sweep_ff;
         wd = '0;
      end else begin
         we = b_write;
         wa = b_ff.addr[AW-1:0];
         wd.valid = 1'b1;
         wd.bri   = b_ff.bri;
         wd.depth = b_ff.z;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (move) rd_ff <= mem[head.addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= zps_pkg::BK_SWEEP;
         sweep_ff    <= '0;
         clr_pend_ff <= 1'b0;
         b_v_ff      <= 1'b0;
         lw_en_ff    <= 1'b0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sweep_ff    <= sweep_in;
         clr_pend_ff <= clr_pend_in;
         b_v_ff      <= b_v_in;
         rv_ff       <= rv_in;
         // A write that lands with no entry following it is already in
         // memory by the time the next entry reads.
         if (move || load_clear || b_fire) lw_en_ff <= move && b_write;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         b_ff       <= head;
         lw_addr_ff <= wa;
         lw_data_ff <= wd;
      end else if (load_clear) begin
         b_ff.op  <= zps_pkg::BOP_NONE;
         b_ff.idx <= '0;
      end
      if (b_fire) begin
         r_drawn_ff <= b_write;
         r_idx_ff   <= b_ff.idx;
         r_bri_ff   <= '0;
         r_dep_ff   <= '0;
         r_occ_ff   <= 1'b0;
         if (b_ff.op == zps_pkg::BOP_READ && cur.valid) begin
            r_bri_ff <= cur.bri;
            r_dep_ff <= cur.depth;
            r_occ_ff <= 1'b1;
         end
      end
   end

   assign rsp_chan.valid            = rv_ff;
   assign rsp_chan.drawn            = r_drawn_ff;
   assign rsp_chan.pixel_index      = r_idx_ff;
   assign rsp_chan.pixel_brightness = r_bri_ff;
   assign rsp_chan.pixel_depth      = r_dep_ff;
   assign rsp_chan.pixel_occupied   = r_occ_ff;
endmodule

// File: design/zbuffer_point_splat_unit.sv
// Top level of the z-buffered point splatter: configuration registers and
// the front end, queue and back end. Depends on zps_pkg, zps_if and modules.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    op, point_x/y/z, brightness, masked, read_index
//   rsp_chan  out        valid/ready    drawn, pixel_index/brightness/depth/occupied
//   csr_chan  in         valid/ready    index, data (always ready)
//
// One request per cycle is sustained while responses are taken and no sweep
// runs; a request passes the projection pipeline, the queue, the memory read
// register and the response register. A clear request holds the back end
// while the memory is swept one pixel a cycle; the same sweep runs after
// reset. Requests are accepted during a sweep until the queue and the front end fill.
module zbuffer_point_splat_unit #(
   parameter int SCREEN_W = 512,
   parameter int SCREEN_H = 512
) (
   input  logic      clock,
   input  logic      reset,
   zps_req_if.sink   req_chan,
   zps_rsp_if.source rsp_chan,
   zps_csr_if.sink   csr_chan
);
   logic [23:0]        scale_ff;
   logic signed [15:0] shift_x_ff, shift_y_ff;

   logic               push, full, pop, head_valid;
   zps_pkg::entry_type push_entry, head;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= 24'd45875;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            zps_pkg::CSR_SCALE:   scale_ff   <= csr_chan.data;
            zps_pkg::CSR_SHIFT_X: shift_x_ff <= csr_chan.data[15:0];
            zps_pkg::CSR_SHIFT_Y: shift_y_ff <= csr_chan.data[15:0];
            default: ;
         endcase
      end
   end

   zps_front #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_front (
      .clock, .reset, .req_chan,
      .scale(scale_ff), .shift_x(shift_x_ff), .shift_y(shift_y_ff),
      .push, .push_entry, .full
   );

   zps_queue u_queue (
      .clock, .reset, .push, .push_entry, .full, .pop, .head_valid, .head
   );

   zps_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
      .clock, .reset, .head_valid, .head, .pop, .rsp_chan
   );
endmodule

// File: design/zps_checker.sv
// Port-level checks for the z-buffered point splatter, bound to the top
// level. Depends only on the top level's ports.
module zps_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_drawn,
   input logic        rsp_occupied,
   input logic [17:0] rsp_index
);
   // A held response keeps its valid and its index.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_index))
      else $error("response changed while stalled");
   // No response can come out of the reset sweep.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response straight after reset");
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");
   // A plot result never reports an occupied read.
   a_drawn_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drawn |-> !rsp_occupied)
      else $error("drawn and occupied together");
endmodule

bind zbuffer_point_splat_unit zps_checker u_zps_checker (
   .clock(clock),
   .reset(reset),
   .csr_ready(csr_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_drawn(rsp_chan.drawn),
   .rsp_occupied(rsp_chan.pixel_occupied),
   .rsp_index(rsp_chan.pixel_index)
);
